// ===== design/lodsh_pkg.sv =====
// ----------------------------------------------------------------------------
// lodsh_pkg
// Shared types and constants for the level-of-detail selector with hysteresis.
// ----------------------------------------------------------------------------
package lodsh_pkg;

  // number of threshold registers in the register map
  localparam int unsigned NUM_THR = 6;
  // level index width, levels run 0 to NUM_THR
  localparam int unsigned LVL_W   = 3;
  // number of levels the mask can describe
  localparam int unsigned NUM_LVL = NUM_THR + 1;
  // Q16.8 size and threshold width
  localparam int unsigned SIZE_W  = 24;
  // Q0.16 hysteresis width
  localparam int unsigned HYST_W  = 16;
  // scale factor width (one plus or minus h, in Q1.16)
  localparam int unsigned FAC_W   = HYST_W + 1;
  // scaled threshold product width
  localparam int unsigned PROD_W  = SIZE_W + FAC_W;

  typedef logic [NUM_THR-1:0][SIZE_W-1:0] thr_vec_t;
  typedef logic [NUM_THR-1:0][PROD_W-1:0] prod_vec_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_THR  = 2'd1,
    ST_NO_LEVEL = 2'd2
  } status_e;

  // register indexes of the configuration map
  typedef enum logic [2:0] {
    REG_COUNT = 3'd0,
    REG_THR_A = 3'd1,
    REG_THR_B = 3'd2,
    REG_THR_C = 3'd3,
    REG_THR_D = 3'd4,
    REG_THR_E = 3'd5,
    REG_THR_F = 3'd6,
    REG_HYST  = 3'd7
  } reg_idx_e;

  // load enables of the compare stages
  typedef struct packed {
    logic s2;
    logic s3;
  } cmp_en_t;

endpackage

// ===== design/lodsh_cmp.sv =====
// ----------------------------------------------------------------------------
// lodsh_cmp
// Scales every threshold by one minus and one plus the hysteresis fraction,
// registers the products, then registers the compare flags against the size.
// ----------------------------------------------------------------------------
module lodsh_cmp #(
  parameter int unsigned MAX_THRESHOLDS = 6
) (
  input  logic                                clk_i,
  input  lodsh_pkg::cmp_en_t                  en_i,
  input  logic [lodsh_pkg::SIZE_W-1:0]        size_i,
  input  lodsh_pkg::thr_vec_t                 thr_i,
  input  logic [lodsh_pkg::HYST_W-1:0]        hyst_i,
  output logic [lodsh_pkg::NUM_THR-1:0]       lt_raw_o,
  output logic [lodsh_pkg::NUM_THR-1:0]       lt_lo_o,
  output logic [lodsh_pkg::NUM_THR-1:0]       gt_hi_o
);

  logic [lodsh_pkg::FAC_W-1:0]  lo_fac;
  logic [lodsh_pkg::FAC_W-1:0]  hi_fac;
  lodsh_pkg::prod_vec_t         lo_prod_d, lo_prod_q;
  lodsh_pkg::prod_vec_t         hi_prod_d, hi_prod_q;
  logic [lodsh_pkg::SIZE_W-1:0] size_q;
  logic [lodsh_pkg::PROD_W-1:0] size_scaled;
  logic [lodsh_pkg::NUM_THR-1:0] lt_raw_d, lt_lo_d, gt_hi_d;
  logic [lodsh_pkg::NUM_THR-1:0] lt_raw_q, lt_lo_q, gt_hi_q;

  // one minus h and one plus h in Q1.16
  assign lo_fac = {1'b1, {lodsh_pkg::HYST_W{1'b0}}} - {1'b0, hyst_i};
  assign hi_fac = {1'b1, {lodsh_pkg::HYST_W{1'b0}}} + {1'b0, hyst_i};

  // one multiplier pair per threshold lane in use
  for (genvar i = 0; i < lodsh_pkg::NUM_THR; i++) begin : g_lane
    if (i < MAX_THRESHOLDS) begin : g_mul
      assign lo_prod_d[i] = {{lodsh_pkg::FAC_W{1'b0}}, thr_i[i]}
                            * {{lodsh_pkg::SIZE_W{1'b0}}, lo_fac};
      assign hi_prod_d[i] = {{lodsh_pkg::FAC_W{1'b0}}, thr_i[i]}
                            * {{lodsh_pkg::SIZE_W{1'b0}}, hi_fac};
    end else begin : g_off
      assign lo_prod_d[i] = '0;
      assign hi_prod_d[i] = '0;
    end
  end

  // product stage
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      lo_prod_q <= lo_prod_d;
      hi_prod_q <= hi_prod_d;
      size_q    <= size_i;
    end
  end

  // size times one in Q1.16
  assign size_scaled = {1'b0, size_q, {lodsh_pkg::HYST_W{1'b0}}};

  // compare flags per lane
  always_comb begin
    for (int i = 0; i < lodsh_pkg::NUM_THR; i++) begin
      lt_raw_d[i] = (size_q < thr_i[i]);
      lt_lo_d[i]  = (size_scaled < lo_prod_q[i]);
      gt_hi_d[i]  = (size_scaled > hi_prod_q[i]);
    end
  end

  // flag stage
  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      lt_raw_q <= lt_raw_d;
      lt_lo_q  <= lt_lo_d;
      gt_hi_q  <= gt_hi_d;
    end
  end

  assign lt_raw_o = lt_raw_q;
  assign lt_lo_o  = lt_lo_q;
  assign gt_hi_o  = gt_hi_q;

endmodule

// ===== design/lod_select_hysteresis_unit.sv =====
// ----------------------------------------------------------------------------
// lod_select_hysteresis_unit
// Selects a level of detail from a projected size with hysteresis against
// up to six descending thresholds, then falls back to the nearest available
// level.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                   payload
//  in       to block   in_valid_i / in_stall_o     projected_size, prior_level,
//                                                  available_mask
//  out      from block out_valid_o / out_stall_i   chosen_level, status
//  config   to block   psel / penable / pwrite     paddr, pwdata, prdata
//
//  Six register stages: input, products, compare flags, finer walk, coarser
//  walk, outward search into the output register. One item is taken per
//  cycle while the output is not stalled; the depth is set by the threshold
//  multipliers and the two level walks.
//  Each stage holds only while the stage after it is full and held, so
//  bubbles close up under a stalled output and no item is lost or repeated.
//  Reset clears valid bits and all configuration registers to zero.
// ----------------------------------------------------------------------------
module lod_select_hysteresis_unit #(
  parameter int unsigned MAX_THRESHOLDS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] projected_size_i,
  input  logic [2:0]  prior_level_i,
  input  logic [6:0]  available_mask_i,
  // item output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  chosen_level_o,
  output logic [1:0]  status_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NSTG = 6;
  localparam int unsigned NT   = lodsh_pkg::NUM_THR;
  localparam int unsigned LW   = lodsh_pkg::LVL_W;
  localparam int unsigned NL   = lodsh_pkg::NUM_LVL;

  // configuration registers
  logic [2:0]                   count_q;
  lodsh_pkg::thr_vec_t          thr_q;
  logic [lodsh_pkg::HYST_W-1:0] hyst_q;
  lodsh_pkg::reg_idx_e          reg_idx;
  logic                         cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = lodsh_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      thr_q   <= '0;
      hyst_q  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        lodsh_pkg::REG_COUNT: count_q   <= pwdata[2:0];
        lodsh_pkg::REG_THR_A: thr_q[0]  <= pwdata[23:0];
        lodsh_pkg::REG_THR_B: thr_q[1]  <= pwdata[23:0];
        lodsh_pkg::REG_THR_C: thr_q[2]  <= pwdata[23:0];
        lodsh_pkg::REG_THR_D: thr_q[3]  <= pwdata[23:0];
        lodsh_pkg::REG_THR_E: thr_q[4]  <= pwdata[23:0];
        lodsh_pkg::REG_THR_F: thr_q[5]  <= pwdata[23:0];
        lodsh_pkg::REG_HYST:  hyst_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      lodsh_pkg::REG_COUNT: prdata = {29'd0, count_q};
      lodsh_pkg::REG_THR_A: prdata = {8'd0, thr_q[0]};
      lodsh_pkg::REG_THR_B: prdata = {8'd0, thr_q[1]};
      lodsh_pkg::REG_THR_C: prdata = {8'd0, thr_q[2]};
      lodsh_pkg::REG_THR_D: prdata = {8'd0, thr_q[3]};
      lodsh_pkg::REG_THR_E: prdata = {8'd0, thr_q[4]};
      lodsh_pkg::REG_THR_F: prdata = {8'd0, thr_q[5]};
      lodsh_pkg::REG_HYST:  prdata = {16'd0, hyst_q};
      default: prdata = '0;
    endcase
  end

  // thresholds in use, saturated at the lane count
  logic [LW-1:0] n_thr;
  logic [NL-1:0] lvl_mask;
  logic          thr_bad;

  assign n_thr = (count_q > LW'(MAX_THRESHOLDS)) ? LW'(MAX_THRESHOLDS) : count_q;

  always_comb begin
    lvl_mask = '0;
    thr_bad  = 1'b0;
    for (int i = 0; i < NL; i++) begin
      lvl_mask[i] = (LW'(i) <= n_thr);
    end
    for (int i = 0; i < NT; i++) begin
      if (LW'(i) < n_thr) begin
        if (thr_q[i] == '0) thr_bad = 1'b1;
        if (i > 0 && thr_q[i] >= thr_q[(i > 0) ? i - 1 : 0]) thr_bad = 1'b1;
      end
    end
  end

  // pipeline valid bits and per-stage advance
  logic [NSTG-1:0] vld_q;
  logic [NSTG:0]   adv;

  always_comb begin
    adv[NSTG] = !out_stall_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (adv[k]) vld_q[k] <= (k == 0) ? in_valid_i : vld_q[(k > 0) ? k - 1 : 0];
      end
    end
  end

  // stage 1: input item
  logic [23:0] size1_q;
  logic [2:0]  prior1_q;
  logic [6:0]  mask1_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      size1_q  <= projected_size_i;
      prior1_q <= prior_level_i;
      mask1_q  <= available_mask_i;
    end
  end

  // stage 2: side data next to the products
  logic [NL-1:0]       avail_d2;
  lodsh_pkg::status_e  st_d2;
  lodsh_pkg::status_e  st2_q;
  logic [NL-1:0]       avail2_q;
  logic [LW-1:0]       prior2_q;
  logic                nopri2_q;

  assign avail_d2 = mask1_q & lvl_mask;

  always_comb begin
    priority if (thr_bad)          st_d2 = lodsh_pkg::ST_BAD_THR;
    else if (avail_d2 == '0)       st_d2 = lodsh_pkg::ST_NO_LEVEL;
    else                           st_d2 = lodsh_pkg::ST_OK;
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      st2_q    <= st_d2;
      avail2_q <= avail_d2;
      prior2_q <= prior1_q;
      nopri2_q <= (prior1_q > n_thr);
    end
  end

  // stages 2 and 3: products and compare flags
  lodsh_pkg::cmp_en_t cmp_en;
  logic [NT-1:0]      lt_raw3, lt_lo3, gt_hi3;

  assign cmp_en.s2 = adv[1];
  assign cmp_en.s3 = adv[2];

  lodsh_cmp #(
    .MAX_THRESHOLDS(MAX_THRESHOLDS)
  ) u_cmp (
    .clk_i   (clk_i),
    .en_i    (cmp_en),
    .size_i  (size1_q),
    .thr_i   (thr_q),
    .hyst_i  (hyst_q),
    .lt_raw_o(lt_raw3),
    .lt_lo_o (lt_lo3),
    .gt_hi_o (gt_hi3)
  );

  lodsh_pkg::status_e st3_q;
  logic [NL-1:0]      avail3_q;
  logic [LW-1:0]      prior3_q;
  logic               nopri3_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      st3_q    <= st2_q;
      avail3_q <= avail2_q;
      prior3_q <= prior2_q;
      nopri3_q <= nopri2_q;
    end
  end

  // stage 4: walk finer from the start level
  logic [NT-1:0] fin_flags;
  logic [LW-1:0] start_lvl;
  logic [LW-1:0] l1_d;
  logic [NT-1:0] cor_d;

  always_comb begin
    start_lvl = nopri3_q ? '0 : prior3_q;
    cor_d     = nopri3_q ? '0 : gt_hi3;
    for (int j = 0; j < NT; j++) begin
      fin_flags[j] = (LW'(j) < n_thr) && (nopri3_q ? lt_raw3[j] : lt_lo3[j]);
    end
    l1_d = LW'(NT);
    for (int j = NT - 1; j >= 0; j--) begin
      if (LW'(j) >= start_lvl && !fin_flags[j]) l1_d = LW'(j);
    end
  end

  lodsh_pkg::status_e st4_q;
  logic [NL-1:0]      avail4_q;
  logic [LW-1:0]      l1_q;
  logic [NT-1:0]      cor4_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      st4_q    <= st3_q;
      avail4_q <= avail3_q;
      l1_q     <= l1_d;
      cor4_q   <= cor_d;
    end
  end

  // stage 5: walk coarser while above the widened threshold
  logic [LW-1:0] l2_d;

  always_comb begin
    l2_d = '0;
    for (int j = 0; j < NT; j++) begin
      if (LW'(j) < l1_q && !cor4_q[j]) l2_d = LW'(j + 1);
    end
  end

  lodsh_pkg::status_e st5_q;
  logic [NL-1:0]      avail5_q;
  logic [LW-1:0]      l2_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      st5_q    <= st4_q;
      avail5_q <= avail4_q;
      l2_q     <= l2_d;
    end
  end

  // stage 6: nearest available level, lower side first
  logic [LW-1:0] pick_d;
  logic          found;
  logic [LW:0]   up_lvl;
  logic [LW-1:0] dn_lvl;

  always_comb begin
    pick_d = l2_q;
    found  = avail5_q[l2_q];
    up_lvl = '0;
    dn_lvl = '0;
    for (int d = 1; d < NL; d++) begin
      dn_lvl = l2_q - LW'(d);
      up_lvl = {1'b0, l2_q} + (LW + 1)'(d);
      if (!found) begin
        if (l2_q >= LW'(d) && avail5_q[dn_lvl]) begin
          pick_d = dn_lvl;
          found  = 1'b1;
        end else if (up_lvl < (LW + 1)'(NL) && avail5_q[up_lvl[LW-1:0]]) begin
          pick_d = up_lvl[LW-1:0];
          found  = 1'b1;
        end
      end
    end
  end

  lodsh_pkg::status_e st6_q;
  logic [LW-1:0]      lvl6_q;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      st6_q  <= st5_q;
      lvl6_q <= (st5_q == lodsh_pkg::ST_OK) ? pick_d : '0;
    end
  end

  assign out_valid_o    = vld_q[NSTG-1];
  assign chosen_level_o = lvl6_q;
  assign status_o       = st6_q;

  // accepted item enters the first stage
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted item not held in first stage");

  // a held result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  // a good result names a level that exists
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == lodsh_pkg::ST_OK) |-> (chosen_level_o <= n_thr))
    else $error("chosen level beyond level count");

  // an ok item in the search stage has some level available
  a_avail_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[4] && st5_q == lodsh_pkg::ST_OK) |-> (avail5_q != '0))
    else $error("ok status with empty availability");

  // error results carry level zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != lodsh_pkg::ST_OK) |-> (chosen_level_o == '0))
    else $error("error result with nonzero level");

endmodule
